@@ rtl/rmq_pkg.sv @@
// shared types, widths and codes for the rotation matrix to quaternion block
package rmq_pkg;

  localparam int DW       = 16;
  localparam int FRAC     = DW - 2;
  localparam int RAD_W    = DW + 2;
  localparam int RADU_W   = DW + 1;
  localparam int DIFF_W   = DW + 1;
  localparam int SW       = (RADU_W + FRAC + 1) / 2;
  localparam int NW       = DIFF_W + FRAC;
  localparam int LOG_SMIN = FRAC / 2;
  localparam int QW       = NW - LOG_SMIN;
  localparam int QDEPTH   = 2;

  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [QW-1:0] Q_LIM = QW'(1) << (DW - 1);
  localparam logic signed [RAD_W-1:0] ONE_FIX = RAD_W'(1) << FRAC;

  localparam logic [1:0] SEL_TRACE = 2'd0;
  localparam logic [1:0] SEL_X     = 2'd1;
  localparam logic [1:0] SEL_Y     = 2'd2;
  localparam logic [1:0] SEL_Z     = 2'd3;

  typedef struct packed {
    logic signed [DW-1:0] m00;
    logic signed [DW-1:0] m01;
    logic signed [DW-1:0] m02;
    logic signed [DW-1:0] m10;
    logic signed [DW-1:0] m11;
    logic signed [DW-1:0] m12;
    logic signed [DW-1:0] m20;
    logic signed [DW-1:0] m21;
    logic signed [DW-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [DW-1:0] q_w;
    logic signed [DW-1:0] q_x;
    logic signed [DW-1:0] q_y;
    logic signed [DW-1:0] q_z;
    logic [1:0]           case_taken;
    logic                 degenerate;
  } res_t;

  typedef struct packed {
    logic              neg;
    logic [DIFF_W-1:0] mag;
  } dterm_t;

  typedef struct packed {
    logic [1:0]        sel;
    logic              deg;
    logic [RADU_W-1:0] rad;
    dterm_t [2:0]      d;
  } work_t;

  typedef struct packed {
    logic [1:0]           sel;
    logic                 deg;
    logic [2:0]           neg;
    logic signed [DW-1:0] big;
  } side_t;

endpackage

@@ rtl/rmq_front.sv @@
// front end: takes a matrix, picks the branch, forms radicand and element sums and differences
module rmq_front import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  mat_t  mat,
  input  logic  q_full,
  output logic  busy,
  output logic  f_valid,
  output work_t f_work
);

  logic signed [RAD_W-1:0] a00, a11, a22, tr, rad;
  logic [1:0]  sel;
  logic        deg;
  work_t       work_next;

  function automatic dterm_t mk_term(logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                                     logic is_sum);
    logic signed [DIFF_W-1:0] d;
    dterm_t t;
    d = is_sum ? (DIFF_W'(a) + DIFF_W'(b)) : (DIFF_W'(a) - DIFF_W'(b));
    t.neg = d[DIFF_W-1];
    t.mag = t.neg ? DIFF_W'(-d) : DIFF_W'(d);
    return t;
  endfunction

  always_comb begin
    a00 = RAD_W'(mat.m00);
    a11 = RAD_W'(mat.m11);
    a22 = RAD_W'(mat.m22);
    tr  = a00 + a11 + a22;
    if (!tr[RAD_W-1] && (tr != '0)) begin
      sel = SEL_TRACE;
      rad = tr + ONE_FIX;
    end else if ((a00 > a11) && (a00 > a22)) begin
      sel = SEL_X;
      rad = ONE_FIX + a00 - a11 - a22;
    end else if (a11 > a22) begin
      sel = SEL_Y;
      rad = ONE_FIX + a11 - a00 - a22;
    end else begin
      sel = SEL_Z;
      rad = ONE_FIX + a22 - a00 - a11;
    end
    deg = rad[RAD_W-1] || (rad == '0);

    work_next.sel = sel;
    work_next.deg = deg;
    work_next.rad = deg ? '0 : rad[RADU_W-1:0];
    case (sel)
      SEL_TRACE: begin
        work_next.d[0] = mk_term(mat.m21, mat.m12, 1'b0);
        work_next.d[1] = mk_term(mat.m02, mat.m20, 1'b0);
        work_next.d[2] = mk_term(mat.m10, mat.m01, 1'b0);
      end
      SEL_X: begin
        work_next.d[0] = mk_term(mat.m21, mat.m12, 1'b0);
        work_next.d[1] = mk_term(mat.m01, mat.m10, 1'b1);
        work_next.d[2] = mk_term(mat.m02, mat.m20, 1'b1);
      end
      SEL_Y: begin
        work_next.d[0] = mk_term(mat.m02, mat.m20, 1'b0);
        work_next.d[1] = mk_term(mat.m01, mat.m10, 1'b1);
        work_next.d[2] = mk_term(mat.m12, mat.m21, 1'b1);
      end
      default: begin
        work_next.d[0] = mk_term(mat.m10, mat.m01, 1'b0);
        work_next.d[1] = mk_term(mat.m02, mat.m20, 1'b1);
        work_next.d[2] = mk_term(mat.m12, mat.m21, 1'b1);
      end
    endcase
  end

  assign busy = f_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (start && !busy) begin
      f_valid <= 1'b1;
    end else if (!q_full) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      f_work <= work_next;
    end
  end

endmodule

@@ rtl/rmq_queue.sv @@
// short queue between the front end and the arithmetic back end
module rmq_queue import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_work,
  input  logic  pop,
  output logic  empty,
  output logic  full,
  output work_t head
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  work_t          mem [QDEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == CW'(QDEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push && !full) - CW'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_work;
    end
  end

endmodule

@@ rtl/rmq_sqrt.sv @@
// pipelined integer square root, one root bit per stage
module rmq_sqrt import rmq_pkg::*; (
  input  logic            clk,
  input  logic [2*SW-1:0] x,
  output logic [SW-1:0]   root
);

  logic [SW+1:0]   rem_s  [SW+1];
  logic [SW-1:0]   root_s [SW+1];
  logic [2*SW-1:0] low_s  [SW+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign low_s[0]  = x;

  for (genvar k = 0; k < SW; k++) begin : g_step
    logic [SW+1:0] shifted, trial;
    logic          take;
    always_comb begin
      shifted = {rem_s[k][SW-1:0], low_s[k][2*SW-1 -: 2]};
      trial   = {root_s[k], 2'b01};
      take    = (shifted >= trial);
    end
    always_ff @(posedge clk) begin
      rem_s[k+1]  <= take ? (shifted - trial) : shifted;
      root_s[k+1] <= {root_s[k][SW-2:0], take};
      low_s[k+1]  <= {low_s[k][2*SW-3:0], 2'b00};
    end
  end

  assign root = root_s[SW];

endmodule

@@ rtl/rmq_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module rmq_div import rmq_pkg::*; (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [SW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [SW-1:0] rem_s [QW+1];
  logic [QW-1:0] quo_s [QW+1];
  logic [QW-1:0] low_s [QW+1];
  logic [SW-1:0] den_s [QW+1];

  // top bits of the dividend are already below the smallest divisor
  assign rem_s[0] = SW'(num[NW-1:QW]);
  assign quo_s[0] = '0;
  assign low_s[0] = num[QW-1:0];
  assign den_s[0] = den;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [SW:0] trial, diff;
    logic        take;
    always_comb begin
      trial = {rem_s[k], low_s[k][QW-1]};
      diff  = trial - {1'b0, den_s[k]};
      take  = (trial >= {1'b0, den_s[k]});
    end
    always_ff @(posedge clk) begin
      rem_s[k+1] <= take ? diff[SW-1:0] : trial[SW-1:0];
      quo_s[k+1] <= {quo_s[k][QW-2:0], take};
      low_s[k+1] <= {low_s[k][QW-2:0], 1'b0};
      den_s[k+1] <= den_s[k];
    end
  end

  assign quo = quo_s[QW];

endmodule

@@ rtl/rmq_back.sv @@
// back end: square root, three dividers, saturation and result register
module rmq_back import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  work_t in_work,
  output logic  done,
  output res_t  res
);

  // square root stage, side data rides alongside
  logic [SW-1:0] v1;
  work_t         wk1 [SW];
  logic [SW-1:0] root;

  rmq_sqrt u_sqrt (
    .clk  (clk),
    .x    ({in_work.rad, FRAC'(0), (2*SW - RADU_W - FRAC)'(0)} >> (2*SW - RADU_W - FRAC)),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= '0;
    end else begin
      v1 <= {v1[SW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    wk1[0] <= in_work;
    for (int k = 1; k < SW; k++) begin
      wk1[k] <= wk1[k-1];
    end
  end

  // prep stage: dividends, divisor and the S/4 component
  logic          v2;
  side_t         sd2;
  logic [NW-1:0] num2 [3];
  logic [SW-1:0] den2;
  logic [SW:0]   big_r;
  work_t         wk_t;

  assign wk_t  = wk1[SW-1];
  assign big_r = ((SW+1)'(root) + (SW+1)'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    sd2.sel <= wk_t.sel;
    sd2.deg <= wk_t.deg;
    for (int i = 0; i < 3; i++) begin
      sd2.neg[i] <= wk_t.d[i].neg;
      num2[i]    <= (NW'(wk_t.d[i].mag) << (FRAC - 1)) + NW'(root >> 1);
    end
    sd2.big <= (big_r > (SW+1)'(SAT_MAX)) ? SAT_MAX : DW'(big_r);
    den2    <= (root == '0) ? SW'(1) : root;
  end

  // divide stage
  logic [QW-1:0] quo [3];
  logic [QW-1:0] v3;
  side_t         sd3 [QW];

  for (genvar i = 0; i < 3; i++) begin : g_div
    rmq_div u_div (
      .clk (clk),
      .num (num2[i]),
      .den (den2),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= '0;
    end else begin
      v3 <= {v3[QW-2:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    sd3[0] <= sd2;
    for (int k = 1; k < QW; k++) begin
      sd3[k] <= sd3[k-1];
    end
  end

  // saturate, place the components by branch
  side_t                sd_o;
  logic signed [DW-1:0] c [3];
  res_t                 res_next;

  assign sd_o = sd3[QW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sd_o.neg[i]) begin
        c[i] = (quo[i] >= Q_LIM) ? SAT_MIN : -DW'(quo[i]);
      end else begin
        c[i] = (quo[i] >= QW'(SAT_MAX)) ? SAT_MAX : DW'(quo[i]);
      end
    end
    res_next.case_taken = sd_o.sel;
    res_next.degenerate = sd_o.deg;
    case (sd_o.sel)
      SEL_TRACE: begin
        res_next.q_w = sd_o.big;
        res_next.q_x = c[0];
        res_next.q_y = c[1];
        res_next.q_z = c[2];
      end
      SEL_X: begin
        res_next.q_w = c[0];
        res_next.q_x = sd_o.big;
        res_next.q_y = c[1];
        res_next.q_z = c[2];
      end
      SEL_Y: begin
        res_next.q_w = c[0];
        res_next.q_x = c[1];
        res_next.q_y = sd_o.big;
        res_next.q_z = c[2];
      end
      default: begin
        res_next.q_w = c[0];
        res_next.q_x = c[1];
        res_next.q_y = c[2];
        res_next.q_z = sd_o.big;
      end
    endcase
    if (sd_o.deg) begin
      res_next.q_w = '0;
      res_next.q_x = '0;
      res_next.q_y = '0;
      res_next.q_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

@@ rtl/rotation_matrix_to_quaternion_top.sv @@
// top level of the rotation matrix to quaternion converter
//
// usage
// - input beat: a full 3x3 matrix on mat (Q2.14 elements), taken at a rising
//   edge where start is high and busy is low
// - output beat: done is high for exactly one cycle with the quaternion,
//   branch code and degenerate flag on res; the receiver cannot hold it off
// - throughput: one matrix per cycle; the back end never stalls, so busy
//   stays low in normal use
// - path to done: front register, queue, 16 square root stages, one prep
//   stage, 24 divider stages and the result register
// - the square root (one bit per stage) and the three parallel dividers
//   (one quotient bit per stage) set the depth
// - reset (rst, synchronous) empties the front register, the queue and all
//   valid bits; beats in flight are dropped and done stays low
// - a non-positive radicand gives a zero quaternion with degenerate set
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  mat_t mat,
  output logic busy,
  output logic done,
  output res_t res
);

  logic  f_valid;
  work_t f_work;
  logic  q_empty, q_full;
  work_t q_head;

  // classify and hold one beat
  rmq_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .mat     (mat),
    .q_full  (q_full),
    .busy    (busy),
    .f_valid (f_valid),
    .f_work  (f_work)
  );

  // decouples front and back; the back end drains it every cycle
  rmq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_work (f_work),
    .pop       (!q_empty),
    .empty     (q_empty),
    .full      (q_full),
    .head      (q_head)
  );

  // arithmetic pipeline and result register
  rmq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_empty),
    .in_work  (q_head),
    .done     (done),
    .res      (res)
  );

endmodule
